// ----- rtl/core/rtu_crc_pkg.sv -----
// Package: shared types, constants and the CRC byte update for the frame checker.
package rtu_crc_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CRC_W         = 16;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam int unsigned MIN_FRAME     = 4;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } frame_status_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rtu_frame_crc_checker_unit.sv -----
// Top level: Modbus RTU frame length and CRC-16 checker, one byte per beat.
//
// Input channel (in_valid/in_ready) carries data_byte and last_byte, one
// frame byte per beat, last_byte set on the final byte of a frame.
// Output channel (out_valid/out_ready) gives one beat per frame: status
// (ok, CRC mismatch, length out of range), the saturating byte count and
// the CRC-16 (poly 0xA001, init 0xFFFF) over all bytes but the last two.
// The last two bytes form the trailer, low byte first.
// The result is registered and appears in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; the byte-wise CRC update and the
// two-byte trailer shift complete in the accepting cycle.
// A single output register holds the result; while it is full and the
// receiver stalls, in_ready drops, otherwise a new byte is taken every
// cycle, including the cycle the result leaves.
// Reset clears the byte count, the trailer bytes and the output valid,
// and loads the CRC with 0xFFFF. Each final byte returns the frame state
// to that reset state for the next frame.
module rtu_frame_crc_checker_unit #(
  parameter int unsigned MAX_FRAME_BYTES = rtu_crc_pkg::MAX_FRAME_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rtu_crc_pkg::BYTE_W-1:0]   data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       frame_status,
  output logic [rtu_crc_pkg::LEN_W-1:0]    frame_length,
  output logic [rtu_crc_pkg::CRC_W-1:0]    computed_crc
);

  localparam logic [rtu_crc_pkg::LEN_W-1:0] LEN_SAT = rtu_crc_pkg::LEN_W'(MAX_FRAME_BYTES + 1);
  localparam logic [rtu_crc_pkg::LEN_W-1:0] LEN_MAX = rtu_crc_pkg::LEN_W'(MAX_FRAME_BYTES);
  localparam logic [rtu_crc_pkg::LEN_W-1:0] LEN_MIN = rtu_crc_pkg::LEN_W'(rtu_crc_pkg::MIN_FRAME);

  logic [rtu_crc_pkg::CRC_W-1:0]  crc_acc;
  logic [rtu_crc_pkg::CRC_W-1:0]  crc_next;
  logic [rtu_crc_pkg::BYTE_W-1:0] dly0;
  logic [rtu_crc_pkg::BYTE_W-1:0] dly1;
  logic [rtu_crc_pkg::LEN_W-1:0]  byte_count;
  logic [rtu_crc_pkg::LEN_W-1:0]  byte_count_next;
  logic [rtu_crc_pkg::CRC_W-1:0]  trailer;
  rtu_crc_pkg::frame_status_t     status_next;
  rtu_crc_pkg::frame_status_t     status_q;
  logic                           in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (byte_count >= rtu_crc_pkg::LEN_W'(2)) begin
      crc_next = rtu_crc_pkg::crc_byte(crc_acc, dly0);
    end else begin
      crc_next = crc_acc;
    end
    if (byte_count < LEN_SAT) begin
      byte_count_next = byte_count + rtu_crc_pkg::LEN_W'(1);
    end else begin
      byte_count_next = byte_count;
    end
    trailer = {data_byte, dly1};
    priority if (byte_count_next < LEN_MIN || byte_count_next > LEN_MAX) begin
      status_next = rtu_crc_pkg::ST_LEN_ERR;
    end else if (trailer != crc_next) begin
      status_next = rtu_crc_pkg::ST_CRC_ERR;
    end else begin
      status_next = rtu_crc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= rtu_crc_pkg::CRC_INIT;
      dly0       <= '0;
      dly1       <= '0;
      byte_count <= '0;
    end else if (in_fire) begin
      if (last_byte) begin
        crc_acc    <= rtu_crc_pkg::CRC_INIT;
        dly0       <= '0;
        dly1       <= '0;
        byte_count <= '0;
      end else begin
        crc_acc    <= crc_next;
        dly0       <= dly1;
        dly1       <= data_byte;
        byte_count <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= last_byte;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      status_q     <= status_next;
      frame_length <= byte_count_next;
      computed_crc <= crc_next;
    end
  end

  assign frame_status = status_q;

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_byte) |=> (byte_count == '0 && crc_acc == rtu_crc_pkg::CRC_INIT))
    else $error("frame state not restarted after last beat");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (out_valid == $past(last_byte)))
    else $error("result valid does not track last beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LEN_SAT)
    else $error("byte count above saturation");

  a_ok_length_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == rtu_crc_pkg::ST_OK) |->
      (frame_length >= LEN_MIN && frame_length <= LEN_MAX))
    else $error("ok status with length out of range");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !last_byte) |=> (byte_count != '0))
    else $error("byte count did not advance");

endmodule

// ----- bench/tb_rtu_frame_crc_checker_unit.sv -----
// Testbench for rtu_frame_crc_checker_unit: directed and random frames against a CRC predictor.
`timescale 1ns / 1ps

module tb_rtu_frame_crc_checker_unit;

  localparam int MAX_BYTES    = rtu_crc_pkg::MAX_FRAME_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 40;
  localparam int HOLD_CYCLES  = 80;

  typedef logic [rtu_crc_pkg::BYTE_W-1:0] frame_bytes_t[$];

  typedef struct {
    rtu_crc_pkg::frame_status_t          status;
    logic [rtu_crc_pkg::LEN_W-1:0]       length;
    logic [rtu_crc_pkg::CRC_W-1:0]       crc;
  } frame_result_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [rtu_crc_pkg::BYTE_W-1:0] data_byte = '0;
  logic                           last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     frame_status;
  logic [rtu_crc_pkg::LEN_W-1:0]  frame_length;
  logic [rtu_crc_pkg::CRC_W-1:0]  computed_crc;

  frame_result_t                  frame_results[$];
  logic [rtu_crc_pkg::CRC_W-1:0]  run_crc;
  logic [rtu_crc_pkg::BYTE_W-1:0] held_old;
  logic [rtu_crc_pkg::BYTE_W-1:0] held_new;
  logic [rtu_crc_pkg::LEN_W-1:0]  run_count;

  int  mismatches = 0;
  int  cycles = 0;
  int  bytes_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;

  rtu_frame_crc_checker_unit #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_status(frame_status),
    .frame_length(frame_length),
    .computed_crc(computed_crc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [rtu_crc_pkg::CRC_W-1:0] crc16_next(
    logic [rtu_crc_pkg::CRC_W-1:0] c, logic [rtu_crc_pkg::BYTE_W-1:0] b);
    logic fb;
    for (int i = 0; i < rtu_crc_pkg::BYTE_W; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ rtu_crc_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic frame_bytes_t with_crc(frame_bytes_t fb);
    logic [rtu_crc_pkg::CRC_W-1:0] c;
    c = rtu_crc_pkg::CRC_INIT;
    foreach (fb[i]) c = crc16_next(c, fb[i]);
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    return fb;
  endfunction

  function automatic frame_bytes_t random_payload(int n);
    frame_bytes_t fb;
    fb = {};
    repeat (n) fb.push_back(rtu_crc_pkg::BYTE_W'($urandom_range(255)));
    return fb;
  endfunction

  task automatic clear_frame_state();
    run_crc   = rtu_crc_pkg::CRC_INIT;
    held_old  = '0;
    held_new  = '0;
    run_count = '0;
  endtask

  task automatic predict_byte(input logic [rtu_crc_pkg::BYTE_W-1:0] b, input logic fin);
    frame_result_t                 r;
    logic [rtu_crc_pkg::CRC_W-1:0] trailer;
    if (run_count >= 2) run_crc = crc16_next(run_crc, held_old);
    held_old = held_new;
    held_new = b;
    if (run_count < MAX_BYTES + 1) run_count++;
    if (fin) begin
      trailer  = {held_new, held_old};
      r.length = run_count;
      r.crc    = run_crc;
      if (run_count < rtu_crc_pkg::MIN_FRAME || run_count > MAX_BYTES)
        r.status = rtu_crc_pkg::ST_LEN_ERR;
      else if (trailer != run_crc) r.status = rtu_crc_pkg::ST_CRC_ERR;
      else r.status = rtu_crc_pkg::ST_OK;
      frame_results.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) clear_frame_state();
    else if (in_valid && in_ready) predict_byte(data_byte, last_byte);
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_results.size() == 0) begin
        report_mismatch("unexpected result, status", frame_status, 0);
      end else begin
        want = frame_results.pop_front();
        if (frame_status !== want.status)
          report_mismatch("frame_status", frame_status, want.status);
        if (frame_length !== want.length)
          report_mismatch("frame_length", frame_length, want.length);
        if (computed_crc !== want.crc)
          report_mismatch("computed_crc", computed_crc, want.crc);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      out_ready <= 1'b0;
      hold_request <= 1'b0;
      hold_left = HOLD_CYCLES;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_byte(input logic [rtu_crc_pkg::BYTE_W-1:0] b, input logic fin);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_bytes_t fb);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic test_directed();
    frame_bytes_t fb;
    fb = with_crc('{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A});
    send_frame(fb);
    fb = '{fb[0], fb[1], fb[2], fb[3], fb[4], fb[5], fb[7], fb[6]};
    send_frame(fb);
    send_frame(with_crc('{8'hFF, 8'hFF}));
    send_frame(with_crc('{8'h00, 8'h00}));
    send_frame('{8'hFF});
    send_frame('{8'h00, 8'h00});
    send_frame('{8'h80, 8'h7F, 8'h01});
    send_frame(with_crc('{8'h11}));
  endtask

  task automatic test_length_limits();
    send_frame(with_crc(random_payload(MAX_BYTES - 2)));
    send_frame(random_payload(MAX_BYTES + 2));
  endtask

  task automatic test_random_frames();
    frame_bytes_t fb;
    int start, kind, n, pos;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        n  = ($urandom_range(19) == 0) ? $urandom_range(19, 30) : $urandom_range(2, 18);
        fb = with_crc(random_payload(n));
        if (kind >= 70) begin
          pos = $urandom_range(fb.size() - 1);
          fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(7));
        end
      end else if (kind < 93) begin
        fb = random_payload($urandom_range(1, 3));
      end else begin
        fb = random_payload($urandom_range(4, 30));
      end
      send_frame(fb);
    end
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_request <= 1'b1;
    repeat (6) send_frame(with_crc(random_payload(2)));
    quiet = 1'b0;
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    repeat (4) send_frame(with_crc(random_payload($urandom_range(2, 6))));
    quiet = 1'b0;
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** rtu_frame_crc_checker_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_length_limits();
    test_random_frames();
    test_backpressure();
    test_no_idle();
    in_valid  <= 1'b0;
    last_byte <= 1'b0;
    @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && frame_results.size() == 0)
      $display("** rtu_frame_crc_checker_unit: PASSED **");
    else $display("** rtu_frame_crc_checker_unit: FAILED **");
    $finish;
  end

endmodule
